/* hdl/jlvr_pkg.sv */
`timescale 1ns / 1ps

package jlvr_pkg;

  localparam int ValueWidth = 32;
  localparam int FracBits   = 16;
  localparam int DtBits     = 16;
  localparam int LimitWidth = 31;
  localparam int DivWidth   = ValueWidth + DtBits;
  localparam int MulSteps   = DtBits;
  localparam int CntWidth   = $clog2(DivWidth);
  localparam int DataWidth  = ValueWidth + DtBits;

  localparam int CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CfgAccelLimit = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgJerkLimit  = 1'b1;

  localparam logic [LimitWidth-1:0] AccelLimitRst = LimitWidth'(64'd1 << FracBits);
  localparam logic [LimitWidth-1:0] JerkLimitRst  = LimitWidth'(64'd5 << FracBits);

  localparam logic [0:0] ReqUpdate = 1'b0;
  localparam logic [0:0] ReqReset  = 1'b1;

endpackage

/* hdl/jerk_limited_velocity_ramp_unit.sv */
`timescale 1ns / 1ps

// Jerk-limited velocity ramp for one axis. Each input transaction carries a
// target velocity (signed Q16.16) and a time step (unsigned Q0.16 seconds), or
// with tuser high a reset of velocity and acceleration. Every transaction
// gives exactly one output transaction with the new velocity. An update with
// a non-zero time step passes through the bit-serial divider forming the
// requested acceleration (one quotient bit a cycle), then the limiting
// steps, then the bit-serial multiplier integrating the acceleration, then
// write-back; the jerk step is multiplied out during the divide. Reset items
// and zero time steps go straight to write-back. One item is worked on at a
// time; the next may be accepted while the previous result still waits on
// the output register. Limits are written through the cfg port; the user
// must write them only while the block is idle; the block does not enforce it.
module jerk_limited_velocity_ramp_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] target_velocity, [47:32] time_step
  input  logic [jlvr_pkg::DataWidth-1:0]        s_axis_tdata,
  // [0] req_type
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] velocity_out
  output logic [jlvr_pkg::ValueWidth-1:0]       m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic [jlvr_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [jlvr_pkg::LimitWidth-1:0]       cfg_wdata_i
);

  localparam int VW = jlvr_pkg::ValueWidth;
  localparam int LW = jlvr_pkg::LimitWidth;
  localparam int TW = jlvr_pkg::DtBits;
  localparam int DW = jlvr_pkg::DivWidth;
  localparam int CW = jlvr_pkg::CntWidth;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StLim1 = 3'd3;
  localparam logic [2:0] StLim2 = 3'd4;
  localparam logic [2:0] StLim3 = 3'd5;
  localparam logic [2:0] StMul  = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [LW-1:0]        accel_lim_q, jerk_lim_q;
  logic signed [VW-1:0] vel_q, vel_d;
  logic signed [VW-1:0] acc_q, acc_d;
  logic                 out_valid_q, out_valid_d;
  logic [VW-1:0]        out_data_q, out_data_d;

  logic signed [VW-1:0] tv_q, tv_d;
  logic [TW-1:0]        ts_q, ts_d;
  logic                 rst_item_q, rst_item_d;
  logic                 hold_q, hold_d;
  logic                 dneg_q, dneg_d;
  logic                 dzero_q, dzero_d;
  logic [DW-1:0]        nq_q, nq_d;
  logic [TW-1:0]        rem_q, rem_d;
  logic [TW-1:0]        tsh_q, tsh_d;
  logic [LW-1:0]        macc_q, macc_d;
  logic [LW-1:0]        mcand_q, mcand_d;
  logic signed [VW-1:0] req_q, req_d;
  logic signed [VW:0]   lo_q, lo_d;
  logic signed [VW:0]   hi_q, hi_d;
  logic signed [VW:0]   s_q, s_d;

  logic signed [VW:0]   diff_w;
  logic [VW-1:0]        mag_w;
  logic [TW:0]          rem_sh_w;
  logic                 qbit_w;
  logic [LW:0]          msum_w;
  logic                 mul_en_w;
  logic [LW-1:0]        qc_w;
  logic signed [VW:0]   acc_ext_w, js_ext_w, req_ext_w, lim_pos_w, lim_neg_w, anew_w;
  logic signed [VW:0]   aabs_w;
  logic signed [VW+1:0] move_w, next_w, d2_w;
  logic                 snap_w, out_free_w;
  logic signed [VW-1:0] next_sat_w;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free_w    = !out_valid_q || m_axis_tready;

  // divider and multiplier datapath
  assign diff_w   = {tv_q[VW-1], tv_q} - {vel_q[VW-1], vel_q};
  assign mag_w    = diff_w[VW] ? VW'(-diff_w) : diff_w[VW-1:0];
  assign rem_sh_w = {rem_q, nq_q[DW-1]};
  assign qbit_w   = (rem_sh_w >= {1'b0, ts_q});
  assign msum_w   = {1'b0, macc_q} + (tsh_q[0] ? {1'b0, mcand_q} : {(LW+1){1'b0}});
  assign mul_en_w = (state_q == StMul) ||
                    ((state_q == StDiv) && (cnt_q < CW'(jlvr_pkg::MulSteps)));

  // limiting
  assign qc_w      = (nq_q > DW'(accel_lim_q)) ? accel_lim_q : nq_q[LW-1:0];
  assign acc_ext_w = {acc_q[VW-1], acc_q};
  assign js_ext_w  = $signed({2'b00, macc_q});
  assign req_ext_w = {req_q[VW-1], req_q};
  assign lim_pos_w = $signed({2'b00, accel_lim_q});
  assign lim_neg_w = -lim_pos_w;
  assign anew_w    = (s_q > lim_pos_w) ? lim_pos_w : ((s_q < lim_neg_w) ? lim_neg_w : s_q);
  assign aabs_w    = anew_w[VW] ? -anew_w : anew_w;

  // integration and snap
  assign move_w = acc_q[VW-1] ? -$signed({3'b000, macc_q}) : $signed({3'b000, macc_q});
  assign next_w = {{2{vel_q[VW-1]}}, vel_q} + move_w;
  assign d2_w   = {{2{tv_q[VW-1]}}, tv_q} - next_w;
  assign snap_w = dzero_q || (d2_w == '0) || (dneg_q != d2_w[VW+1]);

  always_comb begin
    if ((next_w[VW+1:VW-1] == 3'b000) || (next_w[VW+1:VW-1] == 3'b111)) begin
      next_sat_w = next_w[VW-1:0];
    end else if (next_w[VW+1]) begin
      next_sat_w = {1'b1, {(VW-1){1'b0}}};
    end else begin
      next_sat_w = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    vel_d       = vel_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    tv_d        = tv_q;
    ts_d        = ts_q;
    rst_item_d  = rst_item_q;
    hold_d      = hold_q;
    dneg_d      = dneg_q;
    dzero_d     = dzero_q;
    nq_d        = nq_q;
    rem_d       = rem_q;
    tsh_d       = tsh_q;
    macc_d      = macc_q;
    mcand_d     = mcand_q;
    req_d       = req_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    s_d         = s_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (mul_en_w) begin
      macc_d = msum_w[LW:1];
      tsh_d  = {1'b0, tsh_q[TW-1:1]};
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          tv_d       = $signed(s_axis_tdata[VW-1:0]);
          ts_d       = s_axis_tdata[VW+TW-1:VW];
          rst_item_d = (s_axis_tuser == jlvr_pkg::ReqReset);
          hold_d     = (s_axis_tdata[VW+TW-1:VW] == '0);
          if ((s_axis_tuser == jlvr_pkg::ReqReset) ||
              (s_axis_tdata[VW+TW-1:VW] == '0)) begin
            state_d = StFin;
          end else begin
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        dneg_d  = diff_w[VW];
        dzero_d = (diff_w == '0);
        nq_d    = {mag_w, {TW{1'b0}}};
        rem_d   = '0;
        tsh_d   = ts_q;
        macc_d  = '0;
        mcand_d = jerk_lim_q;
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        rem_d = qbit_w ? TW'(rem_sh_w - {1'b0, ts_q}) : rem_sh_w[TW-1:0];
        nq_d  = {nq_q[DW-2:0], qbit_w};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          state_d = StLim1;
        end
      end
      StLim1: begin
        req_d   = dneg_q ? -$signed({1'b0, qc_w}) : $signed({1'b0, qc_w});
        lo_d    = acc_ext_w - js_ext_w;
        hi_d    = acc_ext_w + js_ext_w;
        state_d = StLim2;
      end
      StLim2: begin
        if (req_ext_w > hi_q) begin
          s_d = hi_q;
        end else if (req_ext_w < lo_q) begin
          s_d = lo_q;
        end else begin
          s_d = req_ext_w;
        end
        state_d = StLim3;
      end
      StLim3: begin
        acc_d   = anew_w[VW-1:0];
        mcand_d = aabs_w[LW-1:0];
        macc_d  = '0;
        tsh_d   = ts_q;
        cnt_d   = '0;
        state_d = StMul;
      end
      StMul: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(jlvr_pkg::MulSteps - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free_w) begin
          if (rst_item_q) begin
            vel_d = '0;
            acc_d = '0;
          end else if (!hold_q) begin
            if (snap_w) begin
              vel_d = tv_q;
              acc_d = '0;
            end else begin
              vel_d = next_sat_w;
            end
          end
          out_valid_d = 1'b1;
          out_data_d  = vel_d;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      vel_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      accel_lim_q <= jlvr_pkg::AccelLimitRst;
      jerk_lim_q  <= jlvr_pkg::JerkLimitRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      vel_q       <= vel_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == jlvr_pkg::CfgAccelLimit)) begin
        accel_lim_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == jlvr_pkg::CfgJerkLimit)) begin
        jerk_lim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    tv_q       <= tv_d;
    ts_q       <= ts_d;
    rst_item_q <= rst_item_d;
    hold_q     <= hold_d;
    dneg_q     <= dneg_d;
    dzero_q    <= dzero_d;
    nq_q       <= nq_d;
    rem_q      <= rem_d;
    tsh_q      <= tsh_d;
    macc_q     <= macc_d;
    mcand_q    <= mcand_d;
    req_q      <= req_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    s_q        <= s_d;
  end

endmodule

/* sim/tb_jerk_limited_velocity_ramp_unit.sv */
`timescale 1ns / 1ps

module tb_jerk_limited_velocity_ramp_unit;

  localparam int     ValueWidth    = jlvr_pkg::ValueWidth;
  localparam int     DtBits        = jlvr_pkg::DtBits;
  localparam int     DataWidth     = jlvr_pkg::DataWidth;
  localparam int     LimitWidth    = jlvr_pkg::LimitWidth;
  localparam int     CfgIdxWidth   = jlvr_pkg::CfgIdxWidth;
  localparam longint VelMax        = (longint'(1) <<< (ValueWidth - 1)) - 1;
  localparam longint VelMin        = -VelMax - 1;
  localparam int     WatchdogLimit = 2000;
  localparam int     SettleCycles  = 80;

  typedef struct packed {
    logic                  req;
    logic [ValueWidth-1:0] tgt;
    logic [DtBits-1:0]     dt;
  } ramp_item_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [31:0] target_velocity, [47:32] time_step
  logic [DataWidth-1:0]   s_axis_tdata  = '0;
  // [0] req_type
  logic                   s_axis_tuser  = jlvr_pkg::ReqUpdate;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [31:0] velocity_out
  logic [ValueWidth-1:0]  m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i     = jlvr_pkg::CfgAccelLimit;
  logic [LimitWidth-1:0]  cfg_wdata_i   = '0;

  // model state
  logic [LimitWidth-1:0]  accel_lim;
  logic [LimitWidth-1:0]  jerk_lim;
  longint                 vel_now;
  longint                 acc_now;

  ramp_item_t             item_q[$];
  logic [ValueWidth-1:0]  velocity_q[$];
  ramp_item_t             drv_item;
  logic [ValueWidth-1:0]  want_vel;
  int                     idle_pct      = 19;
  int                     queued_count  = 0;
  int                     rx_count      = 0;
  int                     err_count     = 0;
  int                     quiet_cycles  = 0;

  always #4 clk_i = ~clk_i;

  jerk_limited_velocity_ramp_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  function automatic longint clamp_sym(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  task automatic advance_ramp(input logic req, input logic [ValueWidth-1:0] tgt,
                              input logic [DtBits-1:0] dt);
    longint goal;
    longint amax;
    longint diff;
    longint diff2;
    longint mag;
    longint quo;
    longint jstep;
    longint mv;
    longint nxt;
    if (req == jlvr_pkg::ReqReset) begin
      vel_now = 0;
      acc_now = 0;
    end else if (dt != '0) begin
      goal = longint'($signed(tgt));
      amax = longint'(accel_lim);
      diff = goal - vel_now;
      mag  = (diff < 0) ? -diff : diff;
      quo  = (mag <<< DtBits) / longint'(dt);
      if (quo > amax) quo = amax;
      if (diff < 0) quo = -quo;
      jstep   = (longint'(jerk_lim) * longint'(dt)) >>> DtBits;
      acc_now = clamp_sym(acc_now + clamp_sym(quo - acc_now, jstep), amax);
      mv      = (((acc_now < 0) ? -acc_now : acc_now) * longint'(dt)) >>> DtBits;
      if (acc_now < 0) mv = -mv;
      nxt   = vel_now + mv;
      diff2 = goal - nxt;
      if (diff == 0 || diff2 == 0 || ((diff < 0) != (diff2 < 0))) begin
        vel_now = goal;
        acc_now = 0;
      end else if (nxt > VelMax) begin
        vel_now = VelMax;
      end else if (nxt < VelMin) begin
        vel_now = VelMin;
      end else begin
        vel_now = nxt;
      end
    end
    velocity_q.push_back(vel_now[ValueWidth-1:0]);
  endtask

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= jlvr_pkg::ReqUpdate;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_ramp(s_axis_tuser, s_axis_tdata[ValueWidth-1:0],
                     s_axis_tdata[DataWidth-1:ValueWidth]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_item = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {drv_item.dt, drv_item.tgt};
          s_axis_tuser  <= drv_item.req;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_count++;
        if (velocity_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected velocity transaction, expected none, got %h",
                   $time, m_axis_tdata);
        end else begin
          want_vel = velocity_q.pop_front();
          if (m_axis_tdata !== want_vel) begin
            err_count++;
            $display("%0t: velocity mismatch, expected %h, got %h",
                     $time, want_vel, m_axis_tdata);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic req, input logic [ValueWidth-1:0] tgt,
                            input logic [DtBits-1:0] dt);
    ramp_item_t it;
    it.req = req;
    it.tgt = tgt;
    it.dt  = dt;
    item_q.push_back(it);
    queued_count++;
  endtask

  task automatic write_limit(input logic [CfgIdxWidth-1:0] idx,
                             input logic [LimitWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == jlvr_pkg::CfgAccelLimit) accel_lim = val;
    else jerk_lim = val;
  endtask

  task automatic drain();
    while (rx_count != queued_count) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [LimitWidth-1:0] rand_limit();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return LimitWidth'($urandom_range(1 << 12, 1 << 20));
      3:       return LimitWidth'($urandom_range(1 << 20, 1 << 26));
      default: return LimitWidth'($urandom);
    endcase
  endfunction

  // mostly ramps toward a held goal, with some noise and resets
  task automatic queue_random(input int count);
    logic [ValueWidth-1:0] aim;
    logic [ValueWidth-1:0] tgt;
    logic [DtBits-1:0]     dt;
    int                    pick;
    aim = $urandom_range(0, 32'h0014_0000);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        if ($urandom_range(1)) aim = $urandom;
        else aim = $urandom_range(0, 32'h0014_0000);
        if ($urandom_range(1)) aim = -aim;
      end
      tgt = (pick >= 88 && pick < 94) ? $urandom : aim;
      case ($urandom_range(3))
        0:       dt = DtBits'($urandom_range(1, 255));
        1:       dt = DtBits'($urandom_range(256, 16'h1fff));
        2:       dt = DtBits'($urandom);
        default: dt = $urandom_range(1) ? '0 : '1;
      endcase
      queue_item((pick >= 95) ? jlvr_pkg::ReqReset : jlvr_pkg::ReqUpdate, tgt, dt);
    end
  endtask

  initial begin
    accel_lim = jlvr_pkg::AccelLimitRst;
    jerk_lim  = jlvr_pkg::JerkLimitRst;
    vel_now   = 0;
    acc_now   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: hold, snap, ramps and range ends
    queue_item(jlvr_pkg::ReqReset,  32'hffff_ffff, 16'hffff);
    queue_item(jlvr_pkg::ReqUpdate, 32'h0000_0000, 16'h0000);
    queue_item(jlvr_pkg::ReqUpdate, 32'h0000_0000, 16'h0100);
    repeat (5) queue_item(jlvr_pkg::ReqUpdate, 32'h000a_0000, 16'h1000);
    queue_item(jlvr_pkg::ReqUpdate, 32'h000a_0000, 16'h0000);
    queue_item(jlvr_pkg::ReqUpdate, 32'h7fff_ffff, 16'hffff);
    queue_item(jlvr_pkg::ReqUpdate, 32'h8000_0000, 16'h0001);
    queue_item(jlvr_pkg::ReqUpdate, 32'h8000_0000, 16'hffff);
    queue_item(jlvr_pkg::ReqReset,  32'h0000_0000, 16'h0000);
    drain();

    // widest limits: swing end to end
    write_limit(jlvr_pkg::CfgAccelLimit, '1);
    write_limit(jlvr_pkg::CfgJerkLimit, '1);
    queue_item(jlvr_pkg::ReqUpdate, 32'h8000_0000, 16'hffff);
    queue_item(jlvr_pkg::ReqUpdate, 32'h8000_0000, 16'hffff);
    queue_item(jlvr_pkg::ReqUpdate, 32'h7fff_ffff, 16'hffff);
    queue_item(jlvr_pkg::ReqUpdate, 32'h8000_0000, 16'h8000);
    queue_item(jlvr_pkg::ReqUpdate, 32'h7fff_ffff, 16'h0001);
    queue_item(jlvr_pkg::ReqReset,  32'h1234_5678, 16'hffff);
    drain();

    // zero limits: only resets move the velocity
    write_limit(jlvr_pkg::CfgAccelLimit, '0);
    write_limit(jlvr_pkg::CfgJerkLimit, '0);
    queue_item(jlvr_pkg::ReqUpdate, 32'h0001_0000, 16'h4000);
    queue_item(jlvr_pkg::ReqUpdate, 32'h0000_0000, 16'h4000);
    queue_random(20);
    drain();

    write_limit(jlvr_pkg::CfgAccelLimit, '1);
    write_limit(jlvr_pkg::CfgJerkLimit, '0);
    queue_random(20);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_limit(jlvr_pkg::CfgAccelLimit, rand_limit());
      write_limit(jlvr_pkg::CfgJerkLimit, rand_limit());
      idle_pct = (phase == 2) ? 0 : 19;
      queue_random(100);
      drain();
    end

    if (err_count == 0 && velocity_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
